[hdl/tdt_pkg.sv]
// types and constants for the task dependence tracker
// no dependencies
`default_nettype none
package tdt_pkg;
    localparam int TableEntriesDef = 64;
    localparam int MaxReadersDef = 16;
    localparam int MaxTasksDef = 64;
    localparam int TaskW = 6;
    localparam int AddrW = 64;
    localparam int CountW = 6;

    localparam logic CmdRegister = 1'b0;
    localparam logic CmdRelease = 1'b1;
    localparam logic KindEdge = 1'b0;
    localparam logic KindDone = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [TaskW-1:0]  task_id;
        logic [AddrW-1:0]  address;
        logic              is_write;
        logic              first_of_task;
        logic              last_of_task;
    } tdt_req_t;

    typedef struct packed {
        logic              kind;
        logic [TaskW-1:0]  pred_task;
        logic [TaskW-1:0]  succ_task;
        logic [CountW-1:0] dep_count;
        logic              table_full;
        logic              readers_full;
        logic              last;
    } tdt_res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_SCAN, ST_FETCH, ST_DECIDE, ST_RD_WAIT, ST_RD_USE,
        ST_EDGE, ST_SHIFT_RD, ST_SHIFT_WR, ST_DONE, ST_OUT
    } tdt_state_t;
endpackage
`default_nettype wire

[hdl/task_dependence_tracker.sv]
// task dependence tracker top level: address table, reader memory, sequencer
// depends on tdt_pkg
`default_nettype none
// One request at a time. After reset a pass clears the predecessor matrix, one row per
// cycle. Each request scans the table one entry per cycle through the shared tag
// comparator behind a registered tag read, fetches the matching entry and decides, then
// walks readers through the reader memory (one read port, one write port), with a matrix
// check per edge; results leave through an output register that holds each one until
// m_ready takes it.
module task_dependence_tracker
    import tdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDef,
    parameter int MAX_READERS = MaxReadersDef,
    parameter int MAX_TASKS = MaxTasksDef
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tdt_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output tdt_res_t      m_data
);
    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int RW = $clog2(MAX_READERS + 1);
    localparam int MW = $clog2(MAX_TASKS);
    localparam int DEPTH = TABLE_ENTRIES * MAX_READERS;
    localparam int AW = $clog2(DEPTH);

    logic [TABLE_ENTRIES-1:0] ev_reg, wv_reg;
    logic [AddrW-1:0] tag_mem [TABLE_ENTRIES];
    logic [TaskW-1:0] wid_mem [TABLE_ENTRIES];
    logic [RW-1:0] rc_mem [TABLE_ENTRIES];
    logic [TaskW-1:0] rd_mem [DEPTH];
    logic [MAX_TASKS-1:0] pm_mem [MAX_TASKS];

    tdt_state_t state_reg, state_next;
    tdt_req_t req_reg;
    logic [EW:0] scan_reg, scan_next;
    logic hit_reg, hit_next;
    logic [EW-1:0] ent_reg, ent_next;
    logic free_ok_reg, free_ok_next;
    logic [EW-1:0] free_reg, free_next;
    logic [RW-1:0] idx_reg, idx_next;
    logic [TaskW-1:0] pred_reg, pred_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic tf_reg, tf_next, rf_reg, rf_next;
    logic [MW:0] clr_reg, clr_next;
    logic m_valid_reg, m_valid_next;
    tdt_res_t m_data_reg, m_data_next;
    logic [TaskW-1:0] rdq_reg;
    logic [MAX_TASKS-1:0] pmq_reg;
    logic [AddrW-1:0] tagq_reg;
    logic [TaskW-1:0] widq_reg;
    logic [RW-1:0] rcq_reg;

    logic rd_we;
    logic [AW-1:0] rd_wa, rd_ra;
    logic [TaskW-1:0] rd_wd;
    logic pm_we;
    logic [MW-1:0] pm_wa;
    logic [MAX_TASKS-1:0] pm_wd;
    logic ent_we;
    logic [EW-1:0] ent_wa;
    logic ev_set, ev_clr, wv_set, wv_clr, wid_we, rc_we;
    logic [RW-1:0] rc_wd;
    logic [EW-1:0] scan_idx;
    logic [EW-1:0] prev_idx;
    logic [RW-1:0] rc_cur;
    logic [MW-1:0] succ_row;

    assign scan_idx = scan_reg[EW-1:0];
    assign prev_idx = EW'(scan_reg - 1'b1);
    assign rc_cur = rcq_reg;
    assign succ_row = req_reg.task_id[MW-1:0];
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    function automatic logic [AW-1:0] raddr(input logic [EW-1:0] e, input logic [RW-1:0] i);
        logic [AW+RW-1:0] a;
        a = (AW+RW)'(e) * (AW+RW)'(MAX_READERS) + (AW+RW)'(i);
        return a[AW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            ev_reg <= '0;
            wv_reg <= '0;
            clr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
            if (ev_set) ev_reg[ent_wa] <= 1'b1;
            if (ev_clr) ev_reg[ent_wa] <= 1'b0;
            if (wv_set) wv_reg[ent_wa] <= 1'b1;
            if (wv_clr) wv_reg[ent_wa] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) req_reg <= s_data;
        scan_reg <= scan_next;
        hit_reg <= hit_next;
        ent_reg <= ent_next;
        free_ok_reg <= free_ok_next;
        free_reg <= free_next;
        idx_reg <= idx_next;
        pred_reg <= pred_next;
        tf_reg <= tf_next;
        rf_reg <= rf_next;
        m_data_reg <= m_data_next;
        if (ent_we) tag_mem[ent_wa] <= req_reg.address;
        if (wid_we) wid_mem[ent_wa] <= req_reg.task_id;
        if (rc_we) rc_mem[ent_wa] <= rc_wd;
        tagq_reg <= tag_mem[scan_idx];
        widq_reg <= wid_mem[ent_reg];
        rcq_reg <= rc_mem[ent_reg];
    end

    always_ff @(posedge aclk) begin
        if (rd_we) rd_mem[rd_wa] <= rd_wd;
        rdq_reg <= rd_mem[rd_ra];
    end

    always_ff @(posedge aclk) begin
        if (pm_we) pm_mem[pm_wa] <= pm_wd;
        pmq_reg <= pm_mem[succ_row];
    end

    always_comb begin
        state_next = state_reg;
        scan_next = scan_reg;
        hit_next = hit_reg;
        ent_next = ent_reg;
        free_ok_next = free_ok_reg;
        free_next = free_reg;
        idx_next = idx_reg;
        pred_next = pred_reg;
        cnt_next = cnt_reg;
        tf_next = tf_reg;
        rf_next = rf_reg;
        clr_next = clr_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        rd_we = 1'b0;
        rd_wa = raddr(ent_reg, idx_reg);
        rd_ra = raddr(ent_reg, idx_reg);
        rd_wd = req_reg.task_id;
        pm_we = 1'b0;
        pm_wa = succ_row;
        pm_wd = pmq_reg | (MAX_TASKS'(1) << pred_reg[MW-1:0]);
        ent_we = 1'b0;
        ent_wa = ent_reg;
        ev_set = 1'b0;
        ev_clr = 1'b0;
        wv_set = 1'b0;
        wv_clr = 1'b0;
        wid_we = 1'b0;
        rc_we = 1'b0;
        rc_wd = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                pm_we = 1'b1;
                pm_wa = clr_reg[MW-1:0];
                pm_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (MW+1)'(MAX_TASKS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                scan_next = '0;
                hit_next = 1'b0;
                free_ok_next = 1'b0;
                tf_next = 1'b0;
                rf_next = 1'b0;
                idx_next = '0;
                if (s_valid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // tag of the previous entry comes from the registered tag read
                if (scan_reg != '0 && ev_reg[prev_idx] && tagq_reg == req_reg.address &&
                    !hit_reg) begin
                    hit_next = 1'b1;
                    ent_next = prev_idx;
                end
                if (scan_reg < (EW+1)'(TABLE_ENTRIES)) begin
                    if (!ev_reg[scan_idx] && !free_ok_reg) begin
                        free_ok_next = 1'b1;
                        free_next = scan_idx;
                    end
                    scan_next = scan_reg + 1'b1;
                end else state_next = ST_FETCH;
            end
            ST_FETCH: begin
                if (req_reg.cmd == CmdRegister && req_reg.first_of_task) begin
                    pm_we = 1'b1;
                    pm_wd = '0;
                    cnt_next = '0;
                end
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                idx_next = '0;
                if (req_reg.cmd == CmdRelease) begin
                    if (!hit_reg) state_next = ST_DONE;
                    else if (req_reg.is_write) begin
                        if (wv_reg[ent_reg] && widq_reg == req_reg.task_id) begin
                            wv_clr = 1'b1;
                            if (rc_cur == '0) ev_clr = 1'b1;
                        end
                        state_next = ST_DONE;
                    end else if (rc_cur == '0) begin
                        state_next = ST_DONE;
                    end else state_next = ST_RD_WAIT;
                end else begin
                    if (!hit_reg) begin
                        if (!free_ok_reg) tf_next = 1'b1;
                        else begin
                            ent_wa = free_reg;
                            ent_we = 1'b1;
                            ev_set = 1'b1;
                            rc_we = 1'b1;
                            if (req_reg.is_write) begin
                                wv_set = 1'b1;
                                wid_we = 1'b1;
                            end else begin
                                wv_clr = 1'b1;
                                rc_wd = RW'(1);
                                rd_we = 1'b1;
                                rd_wa = raddr(free_reg, '0);
                            end
                        end
                        state_next = ST_DONE;
                    end else if (req_reg.is_write) begin
                        if (rc_cur != '0) state_next = ST_RD_WAIT;
                        else if (wv_reg[ent_reg]) begin
                            pred_next = widq_reg;
                            state_next = ST_EDGE;
                        end else state_next = ST_SHIFT_WR;
                    end else begin
                        if (rc_cur < RW'(MAX_READERS)) begin
                            rd_we = 1'b1;
                            rd_wa = raddr(ent_reg, rc_cur);
                            rc_we = 1'b1;
                            rc_wd = rc_cur + 1'b1;
                        end else rf_next = 1'b1;
                        if (wv_reg[ent_reg]) begin
                            pred_next = widq_reg;
                            state_next = ST_EDGE;
                        end else state_next = ST_DONE;
                    end
                end
            end
            ST_RD_WAIT: state_next = ST_RD_USE;
            ST_RD_USE: begin
                if (req_reg.cmd == CmdRelease) begin
                    if (rdq_reg == req_reg.task_id) begin
                        state_next = ST_SHIFT_RD;
                    end else if (idx_reg + 1'b1 >= rc_cur) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        state_next = ST_RD_WAIT;
                    end
                end else begin
                    pred_next = rdq_reg;
                    state_next = ST_EDGE;
                end
            end
            ST_SHIFT_RD: begin
                if (idx_reg + 1'b1 >= rc_cur) begin
                    rc_we = 1'b1;
                    rc_wd = rc_cur - 1'b1;
                    if (!wv_reg[ent_reg] && rc_cur == RW'(1)) ev_clr = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_ra = raddr(ent_reg, idx_reg + 1'b1);
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                if (req_reg.cmd == CmdRelease) begin
                    rd_we = 1'b1;
                    rd_wd = rdq_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SHIFT_RD;
                end else begin
                    wv_set = 1'b1;
                    wid_we = 1'b1;
                    rc_we = 1'b1;
                    rc_wd = '0;
                    state_next = ST_DONE;
                end
            end
            ST_EDGE: begin
                if (!m_valid_reg || m_ready) begin
                    if (!pmq_reg[pred_reg[MW-1:0]]) begin
                        pm_we = 1'b1;
                        if (cnt_reg != '1) cnt_next = cnt_reg + 1'b1;
                        m_valid_next = 1'b1;
                        m_data_next = '{KindEdge, pred_reg, req_reg.task_id,
                            (cnt_reg != '1) ? cnt_reg + 1'b1 : cnt_reg, 1'b0, 1'b0, 1'b0};
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (req_reg.is_write && rc_cur != '0 &&
                    idx_reg + 1'b1 < rc_cur && idx_reg + 1'b1 < RW'(MAX_READERS)) begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_RD_WAIT;
                end else if (req_reg.is_write) state_next = ST_SHIFT_WR;
                else state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next = '{KindDone, '0, '0,
                        (req_reg.cmd == CmdRelease || !(32'(req_reg.task_id) < MAX_TASKS))
                            ? '0 : cnt_reg,
                        tf_reg, rf_reg, 1'b1};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (state_reg == ST_SCAN && !(32'(req_reg.task_id) < MAX_TASKS)) state_next = ST_DONE;
    end

    unused_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("result changed while stalled");
    ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    cnt_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EDGE && cnt_reg == '1) |=> (cnt_reg == '1))
        else $error("edge count not saturating");
endmodule
`default_nettype wire

[test/task_dependence_tracker_tb.sv]
// testbench for task_dependence_tracker: directed and random dependence requests
// checked against an in-bench predictor of the last-writer / readers table
// depends on tdt_pkg and task_dependence_tracker
`default_nettype none
module task_dependence_tracker_tb;
    import tdt_pkg::*;

    localparam int Entries = TableEntriesDef;
    localparam int Readers = MaxReadersDef;
    localparam int Tasks = MaxTasksDef;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tdt_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tdt_res_t m_data;

    task_dependence_tracker u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // predictor state
    bit          tbl_valid [Entries];
    logic [63:0] tbl_tag [Entries];
    bit          wr_valid [Entries];
    logic [5:0]  wr_task [Entries];
    int          rd_count [Entries];
    logic [5:0]  rd_task [Entries][Readers];
    logic [63:0] pred_row [Tasks];
    int          edge_total;

    tdt_res_t    expected_res [$];
    int          n_errors = 0;
    int          n_requests = 0;
    int          n_edges = 0;
    bit          quiet = 1'b0;
    logic [63:0] addr_pool [8];

    function automatic tdt_res_t mk_res(logic kind, logic [5:0] pred, logic [5:0] succ,
                                        int cnt, logic tf, logic rf, logic lst);
        tdt_res_t r;
        r.kind = kind; r.pred_task = pred; r.succ_task = succ;
        r.dep_count = cnt[5:0]; r.table_full = tf; r.readers_full = rf; r.last = lst;
        return r;
    endfunction

    function automatic tdt_req_t mk_req(logic cmd, logic [5:0] tid, logic [63:0] addr,
                                        logic wr, logic first, logic lst);
        tdt_req_t r;
        r.cmd = cmd; r.task_id = tid; r.address = addr;
        r.is_write = wr; r.first_of_task = first; r.last_of_task = lst;
        return r;
    endfunction

    function automatic void queue_res(tdt_res_t r);
        expected_res = {expected_res, r};
    endfunction

    function automatic void note_edge(logic [5:0] succ, logic [5:0] pred);
        if (!pred_row[succ][pred]) begin
            pred_row[succ][pred] = 1'b1;
            if (edge_total < 63) edge_total++;
            queue_res(mk_res(KindEdge, pred, succ, edge_total, 0, 0, 0));
            n_edges++;
        end
    endfunction

    function automatic void predict_deps(tdt_req_t q);
        int e;
        int i;
        logic tf;
        logic rf;
        e = -1;
        tf = 1'b0;
        rf = 1'b0;
        for (i = 0; i < Entries; i++)
            if (e < 0 && tbl_valid[i] && tbl_tag[i] == q.address) e = i;
        if (q.cmd == CmdRelease) begin
            if (e >= 0) begin
                if (q.is_write) begin
                    if (wr_valid[e] && wr_task[e] == q.task_id) wr_valid[e] = 1'b0;
                end else begin
                    for (i = 0; i < rd_count[e]; i++)
                        if (rd_task[e][i] == q.task_id) break;
                    if (i < rd_count[e]) begin
                        for (; i + 1 < rd_count[e]; i++) rd_task[e][i] = rd_task[e][i+1];
                        rd_count[e]--;
                    end
                end
                if (!wr_valid[e] && rd_count[e] == 0) tbl_valid[e] = 1'b0;
            end
            queue_res(mk_res(KindDone, 0, 0, 0, 0, 0, 1));
            return;
        end
        if (q.first_of_task) begin
            pred_row[q.task_id] = '0;
            edge_total = 0;
        end
        if (e < 0) begin
            for (i = 0; i < Entries; i++)
                if (!tbl_valid[i]) break;
            if (i == Entries) begin
                tf = 1'b1;
            end else begin
                tbl_valid[i] = 1'b1;
                tbl_tag[i] = q.address;
                wr_valid[i] = q.is_write;
                wr_task[i] = q.task_id;
                rd_task[i][0] = q.task_id;
                rd_count[i] = q.is_write ? 0 : 1;
            end
        end else if (q.is_write) begin
            if (rd_count[e] != 0) begin
                for (i = 0; i < rd_count[e]; i++) note_edge(q.task_id, rd_task[e][i]);
            end else if (wr_valid[e]) begin
                note_edge(q.task_id, wr_task[e]);
            end
            wr_valid[e] = 1'b1;
            wr_task[e] = q.task_id;
            rd_count[e] = 0;
        end else begin
            if (wr_valid[e]) note_edge(q.task_id, wr_task[e]);
            if (rd_count[e] < Readers) begin
                rd_task[e][rd_count[e]] = q.task_id;
                rd_count[e]++;
            end else begin
                rf = 1'b1;
            end
        end
        queue_res(mk_res(KindDone, 0, 0, edge_total, tf, rf, 1));
    endfunction

    task automatic hold_off(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic send_req(tdt_req_t q);
        if (!quiet && $urandom_range(0, 4) == 0) hold_off($urandom_range(1, 11));
        s_valid <= 1'b1;
        s_data <= q;
        do @(posedge aclk); while (!s_ready);
        predict_deps(q);
        n_requests++;
    endtask

    // result sink with random stall bursts
    int stall_left = 0;
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        tdt_res_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_res.size() == 0) begin
                $error("unexpected result %p", m_data);
                n_errors++;
            end else begin
                w = expected_res.pop_front();
                if (m_data.kind !== w.kind) begin
                    $error("kind exp %0d got %0d", w.kind, m_data.kind); n_errors++;
                end
                if (m_data.pred_task !== w.pred_task) begin
                    $error("pred_task exp %0d got %0d", w.pred_task, m_data.pred_task);
                    n_errors++;
                end
                if (m_data.succ_task !== w.succ_task) begin
                    $error("succ_task exp %0d got %0d", w.succ_task, m_data.succ_task);
                    n_errors++;
                end
                if (m_data.dep_count !== w.dep_count) begin
                    $error("dep_count exp %0d got %0d", w.dep_count, m_data.dep_count);
                    n_errors++;
                end
                if (m_data.table_full !== w.table_full) begin
                    $error("table_full exp %0d got %0d", w.table_full, m_data.table_full);
                    n_errors++;
                end
                if (m_data.readers_full !== w.readers_full) begin
                    $error("readers_full exp %0d got %0d", w.readers_full,
                           m_data.readers_full);
                    n_errors++;
                end
                if (m_data.last !== w.last) begin
                    $error("last exp %0d got %0d", w.last, m_data.last); n_errors++;
                end
            end
        end
    end

    task automatic drain_results();
        hold_off(0);
        while (expected_res.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        send_req(mk_req(CmdRegister, 6'd0, 64'd0, 1'b1, 1'b1, 1'b0));
        send_req(mk_req(CmdRegister, 6'd63, 64'd0, 1'b0, 1'b1, 1'b0));
        send_req(mk_req(CmdRegister, 6'd63, '1, 1'b1, 1'b0, 1'b1));
        send_req(mk_req(CmdRegister, 6'd63, 64'd0, 1'b1, 1'b1, 1'b1));
        send_req(mk_req(CmdRegister, 6'd0, '1, 1'b0, 1'b1, 1'b1));
        send_req(mk_req(CmdRegister, 6'd0, '1, 1'b0, 1'b0, 1'b1));
        send_req(mk_req(CmdRelease, 6'd0, '1, 1'b0, 1'b1, 1'b1));
        send_req(mk_req(CmdRelease, 6'd7, '1, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(CmdRelease, 6'd0, '1, 1'b0, 1'b0, 1'b0));
        send_req(mk_req(CmdRelease, 6'd0, '1, 1'b1, 1'b0, 1'b0));
        send_req(mk_req(CmdRelease, 6'd63, 64'h5a5a, 1'b1, 1'b0, 1'b0));
        send_req(mk_req(CmdRelease, 6'd63, 64'd0, 1'b1, 1'b0, 1'b1));
    endtask

    // one reader more than the list holds overflows it, then a writer collects an edge from every listed reader
    task automatic test_reader_overflow();
        logic [63:0] a;
        a = 64'hdead_beef_0000_1000;
        send_req(mk_req(CmdRegister, 6'd40, a, 1'b1, 1'b1, 1'b1));
        for (int t = 0; t < Readers + 1; t++)
            send_req(mk_req(CmdRegister, 6'(t), a, 1'b0, 1'b1, 1'b1));
        send_req(mk_req(CmdRegister, 6'd3, a, 1'b1, 1'b0, 1'b1));
        send_req(mk_req(CmdRelease, 6'd3, a, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic test_table_full();
        for (int i = 0; i <= Entries; i++)
            send_req(mk_req(CmdRegister, 6'd5, 64'h1_0000 + i, 1'b1, i == 0, 1'b0));
        drain_results();
        for (int i = 0; i <= Entries; i++)
            send_req(mk_req(CmdRelease, 6'd5, 64'h1_0000 + i, 1'b1, 1'b0, 1'b0));
    endtask

    task automatic test_random(int count);
        int sent;
        int n;
        logic [5:0] tid;
        logic [63:0] a;
        logic [95:0] raw;
        tdt_req_t q;
        sent = 0;
        while (sent < count) begin
            if (sent > count - 100) quiet = 1'b1;
            if (sent == count / 2) drain_results();
            if ($urandom_range(0, 4) == 0) begin
                raw = {$urandom, $urandom, $urandom};
                q = raw[$bits(tdt_req_t)-1:0];
                send_req(q);
                sent++;
            end else begin
                tid = 6'($urandom_range(0, Tasks - 1));
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    a = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                    : addr_pool[$urandom_range(0, 7)];
                    send_req(mk_req($urandom_range(0, 3) == 0 ? CmdRelease : CmdRegister,
                                    tid, a, $urandom_range(0, 2) == 0,
                                    k == 0 && $urandom_range(0, 5) == 0, k == n - 1));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom};
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0; wr_valid[i] = 1'b0; rd_count[i] = 0;
        end
        foreach (pred_row[i]) pred_row[i] = '0;
        edge_total = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_reader_overflow();
        test_table_full();
        test_random(400);
        drain_results();
        repeat (300) @(posedge aclk);
        $display("covered %0d requests with %0d dependence edges, including full table,",
                 n_requests, n_edges);
        $display("reader overflow, releases, extreme addresses and task ids");
        if (n_errors == 0 && expected_res.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
hdl/tdt_pkg.sv
hdl/task_dependence_tracker.sv
test/task_dependence_tracker_tb.sv
